[src/brick_occupancy_bitmap_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the brick occupancy bitmap
// Concurrent check wrappers. They compile to nothing when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef BRICK_OCCUPANCY_BITMAP_DEFINES_SVH
`define BRICK_OCCUPANCY_BITMAP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("boc assertion failed");
// next-cycle implication
`define BOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("boc assertion failed");
`else
`define BOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[src/boc_pkg.sv]
// ---------------------------------------------------------------------------
// boc_pkg
// Types and fixed constants of the brick occupancy bitmap.
// ---------------------------------------------------------------------------
package boc_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int VOL_W         = 12;
    localparam int EDGE_W        = 7;
    localparam int GRID_W        = 13;
    localparam int IDX_W         = 12;
    localparam int COORD_W       = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 12;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 40;
    localparam int DIV_STEPS     = 13;
    localparam int DIV_CNT_W     = 4;
    localparam int PROD_W        = 2 * GRID_W;
    localparam int FULL_W        = 3 * GRID_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLUME_SIZE_X = 2'd0,
        REG_VOLUME_SIZE_Y = 2'd1,
        REG_VOLUME_SIZE_Z = 2'd2,
        REG_BRICK_EDGE    = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_RANGE    = 2'd1,
        STATUS_CAPACITY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GRID_X,
        ST_GRID_Y,
        ST_GRID_Z,
        ST_MUL_XY,
        ST_MUL_XYZ,
        ST_DIV_X,
        ST_DIV_Y,
        ST_MEM_RD,
        ST_MEM_UPD,
        ST_DONE
    } state_t;

    localparam logic REQ_WRITE_BIT = 1'b1;

endpackage

[src/brick_occupancy_bitmap.sv]
// ---------------------------------------------------------------------------
// brick_occupancy_bitmap
// One occupancy bit per brick of a voxel volume, with index decode.
// ---------------------------------------------------------------------------
// Usage:
//   cfg channel  : cfg_valid/cfg_ready with cfg_index and cfg_data write the
//                  volume size x/y/z and the brick edge. cfg_ready is always
//                  high. Each write rederives the brick grid (ceiling divide,
//                  x rounded up to a multiple of 8); s_tready is low meanwhile.
//   s channel    : one transaction is one request: read or write one brick
//                  bit by linear index.
//   m channel    : one transaction per request: stored bit, brick x/y/z and
//                  a status code.
// Sequencing: a request that decodes goes through two passes of the shared
//   radix-2 divider, one RAM read, one RAM update and one output load before
//   m_tvalid; a request that fails the capacity check or meets an empty grid
//   goes straight to the output load. The next request is taken once the
//   previous one has left the sequencer, so requests never overlap.
// Reset: the volume size and brick edge registers go to 1 and the grid to
//   8 x 1 x 1. The occupancy store is then swept to zero, one byte a cycle,
//   with s_tready low; config writes are taken during the sweep.
// Stalls: the output register holds its transaction while m_tready is low;
//   one more request may be accepted and worked, then waits in the sequencer.
// ---------------------------------------------------------------------------
`include "brick_occupancy_bitmap_defines.svh"

module brick_occupancy_bitmap #(
    parameter int MAX_BRICKS = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [boc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [boc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [boc_pkg::S_TDATA_W-1:0]    s_tdata,  // [11:0] brick_index, [12] write_value
    input  logic                             s_tuser,  // [0] req_type
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [boc_pkg::M_TDATA_W-1:0]    m_tdata,  // [0] occupied, [12:1] coord_x,
                                                       // [24:13] coord_y, [36:25] coord_z
    output logic [1:0]                       m_tuser   // [1:0] status
);

    localparam int DEPTH  = MAX_BRICKS / boc_pkg::BITS_PER_BYTE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_BRICKS + 1);
    localparam int GW     = boc_pkg::GRID_W;
    localparam int CW     = boc_pkg::COORD_W;

    boc_pkg::state_t state_reg, state_next;
    logic                          dirty_reg, dirty_next;
    logic [boc_pkg::VOL_W-1:0]     vol_x_reg, vol_y_reg, vol_z_reg;
    logic [boc_pkg::EDGE_W-1:0]    edge_reg;
    logic [GW-1:0]                 gx_reg, gx_next, gy_reg, gy_next, gz_reg, gz_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          too_big_reg, too_big_next;
    logic [boc_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic [ADDR_W-1:0]             clr_addr_reg, clr_addr_next;

    // shared divider
    logic [GW-1:0]                 div_rem_reg, div_rem_next;
    logic [GW-1:0]                 div_quo_reg, div_quo_next;
    logic [GW-1:0]                 div_den_reg, div_den_next;
    logic [boc_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [GW:0]                   div_shift, div_diff;
    logic                          div_ge, div_last;
    logic [GW-1:0]                 div_rem_step, div_quo_step;

    // request and result working registers
    logic                          req_reg, req_next;
    logic [boc_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic                          wval_reg, wval_next;
    logic [CW-1:0]                 cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic                          occ_reg, occ_next;
    boc_pkg::status_t              status_reg, status_next;

    // output register
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [boc_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]                    m_tuser_reg, m_tuser_next;

    // multiplier and RAM hookup
    logic [boc_pkg::PROD_W-1:0]    mul_a;
    logic [GW-1:0]                 mul_b;
    logic [boc_pkg::FULL_W-1:0]    mul_p;
    logic                          ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]             ram_wr_addr, ram_rd_addr, byte_addr;
    logic [boc_pkg::BITS_PER_BYTE-1:0] ram_wr_data, ram_rd_data, bit_mask, new_byte;
    logic                          cfg_write;
    logic [GW-1:0]                 ceil_y, ceil_z, ceil_x;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;
    assign s_tready  = (state_reg == boc_pkg::ST_IDLE) && !dirty_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // ceiling-divide dividends: size + edge - 1
    assign ceil_x = {1'b0, vol_x_reg} + GW'(edge_reg) - GW'(1);
    assign ceil_y = {1'b0, vol_y_reg} + GW'(edge_reg) - GW'(1);
    assign ceil_z = {1'b0, vol_z_reg} + GW'(edge_reg) - GW'(1);

    // one restoring step per cycle, MSB first
    assign div_shift    = {div_rem_reg, div_quo_reg[GW-1]};
    assign div_ge       = div_shift >= {1'b0, div_den_reg};
    assign div_diff     = div_shift - {1'b0, div_den_reg};
    assign div_rem_step = div_ge ? GW'(div_diff) : GW'(div_shift);
    assign div_quo_step = {div_quo_reg[GW-2:0], div_ge};
    assign div_last     = div_cnt_reg == boc_pkg::DIV_CNT_W'(boc_pkg::DIV_STEPS - 1);

    // shared multiplier: gx*gy, then (gx*gy)*gz
    always_comb
    begin
        if (state_reg == boc_pkg::ST_MUL_XY)
        begin
            mul_a = boc_pkg::PROD_W'(gx_reg);
            mul_b = gy_reg;
        end
        else
        begin
            mul_a = prod_reg;
            mul_b = gz_reg;
        end
        mul_p = mul_a * mul_b;
    end

    // byte and bit of the addressed brick
    assign byte_addr   = ADDR_W'(idx_reg >> 3);
    assign bit_mask    = boc_pkg::BITS_PER_BYTE'(1) << idx_reg[2:0];
    assign new_byte    = (req_reg != boc_pkg::REQ_WRITE_BIT) ? ram_rd_data :
                         (wval_reg ? (ram_rd_data | bit_mask) : (ram_rd_data & ~bit_mask));
    assign ram_rd_en   = state_reg == boc_pkg::ST_MEM_RD;
    assign ram_rd_addr = byte_addr;
    assign ram_wr_en   = (state_reg == boc_pkg::ST_CLEAR) ||
                         ((state_reg == boc_pkg::ST_MEM_UPD) && req_reg);
    assign ram_wr_addr = (state_reg == boc_pkg::ST_CLEAR) ? clr_addr_reg : byte_addr;
    assign ram_wr_data = (state_reg == boc_pkg::ST_CLEAR) ? '0 : new_byte;

    boc_ram #(
        .WIDTH (boc_pkg::BITS_PER_BYTE),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_x_reg <= boc_pkg::VOL_W'(1);
            vol_y_reg <= boc_pkg::VOL_W'(1);
            vol_z_reg <= boc_pkg::VOL_W'(1);
            edge_reg  <= boc_pkg::EDGE_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (boc_pkg::cfg_reg_t'(cfg_index))
                boc_pkg::REG_VOLUME_SIZE_X: vol_x_reg <= cfg_data;
                boc_pkg::REG_VOLUME_SIZE_Y: vol_y_reg <= cfg_data;
                boc_pkg::REG_VOLUME_SIZE_Z: vol_z_reg <= cfg_data;
                boc_pkg::REG_BRICK_EDGE:    edge_reg  <= cfg_data[boc_pkg::EDGE_W-1:0];
                default:                    vol_x_reg <= vol_x_reg;
            endcase
        end
    end

    // sequencer state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= boc_pkg::ST_CLEAR;
            dirty_reg    <= 1'b0;
            gx_reg       <= GW'(8);
            gy_reg       <= GW'(1);
            gz_reg       <= GW'(1);
            count_reg    <= CNT_W'(8);
            too_big_reg  <= 1'b0;
            clr_addr_reg <= '0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dirty_reg    <= dirty_next;
            gx_reg       <= gx_next;
            gy_reg       <= gy_next;
            gz_reg       <= gz_next;
            count_reg    <= count_next;
            too_big_reg  <= too_big_next;
            clr_addr_reg <= clr_addr_next;
            div_cnt_reg  <= div_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_den_reg <= div_den_next;
        req_reg     <= req_next;
        idx_reg     <= idx_next;
        wval_reg    <= wval_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        occ_reg     <= occ_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        dirty_next    = dirty_reg;
        gx_next       = gx_reg;
        gy_next       = gy_reg;
        gz_next       = gz_reg;
        count_next    = count_reg;
        too_big_next  = too_big_reg;
        prod_next     = prod_reg;
        clr_addr_next = clr_addr_reg;
        div_rem_next  = div_rem_reg;
        div_quo_next  = div_quo_reg;
        div_den_next  = div_den_reg;
        div_cnt_next  = div_cnt_reg;
        req_next      = req_reg;
        idx_next      = idx_reg;
        wval_next     = wval_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        occ_next      = occ_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // division states step the divider; the last step is handled per state
        if ((state_reg == boc_pkg::ST_GRID_X) || (state_reg == boc_pkg::ST_GRID_Y) ||
            (state_reg == boc_pkg::ST_GRID_Z) || (state_reg == boc_pkg::ST_DIV_X) ||
            (state_reg == boc_pkg::ST_DIV_Y))
        begin
            div_rem_next = div_rem_step;
            div_quo_next = div_quo_step;
            div_cnt_next = div_cnt_reg + boc_pkg::DIV_CNT_W'(1);
        end

        unique case (state_reg)
            boc_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = boc_pkg::ST_IDLE;
                end
            end
            boc_pkg::ST_IDLE:
            begin
                if (dirty_reg)
                begin
                    dirty_next = 1'b0;
                    if (edge_reg == '0)
                    begin
                        // grid cannot be formed
                        gx_next      = '0;
                        gy_next      = '0;
                        gz_next      = '0;
                        count_next   = '0;
                        too_big_next = 1'b1;
                    end
                    else
                    begin
                        div_rem_next = '0;
                        div_quo_next = ceil_x;
                        div_den_next = GW'(edge_reg);
                        div_cnt_next = '0;
                        state_next   = boc_pkg::ST_GRID_X;
                    end
                end
                else if (s_tvalid)
                begin
                    req_next  = s_tuser;
                    idx_next  = s_tdata[boc_pkg::IDX_W-1:0];
                    wval_next = s_tdata[boc_pkg::IDX_W];
                    occ_next  = 1'b0;
                    cx_next   = '0;
                    cy_next   = '0;
                    cz_next   = '0;
                    if (too_big_reg)
                    begin
                        status_next = boc_pkg::STATUS_CAPACITY;
                        state_next  = boc_pkg::ST_DONE;
                    end
                    else if ((gx_reg == '0) || (gy_reg == '0))
                    begin
                        // empty grid: nothing to decode, every index out of range
                        status_next = boc_pkg::STATUS_RANGE;
                        state_next  = boc_pkg::ST_DONE;
                    end
                    else
                    begin
                        div_rem_next = '0;
                        div_quo_next = GW'(s_tdata[boc_pkg::IDX_W-1:0]);
                        div_den_next = gx_reg;
                        div_cnt_next = '0;
                        state_next   = boc_pkg::ST_DIV_X;
                    end
                end
            end
            boc_pkg::ST_GRID_X:
            begin
                if (div_last)
                begin
                    // round x count up to a whole byte
                    gx_next      = GW'((div_quo_step + GW'(7)) & ~GW'(7));
                    div_rem_next = '0;
                    div_quo_next = ceil_y;
                    div_den_next = GW'(edge_reg);
                    div_cnt_next = '0;
                    state_next   = boc_pkg::ST_GRID_Y;
                end
            end
            boc_pkg::ST_GRID_Y:
            begin
                if (div_last)
                begin
                    gy_next      = div_quo_step;
                    div_rem_next = '0;
                    div_quo_next = ceil_z;
                    div_den_next = GW'(edge_reg);
                    div_cnt_next = '0;
                    state_next   = boc_pkg::ST_GRID_Z;
                end
            end
            boc_pkg::ST_GRID_Z:
            begin
                if (div_last)
                begin
                    gz_next    = div_quo_step;
                    state_next = boc_pkg::ST_MUL_XY;
                end
            end
            boc_pkg::ST_MUL_XY:
            begin
                prod_next  = boc_pkg::PROD_W'(mul_p);
                state_next = boc_pkg::ST_MUL_XYZ;
            end
            boc_pkg::ST_MUL_XYZ:
            begin
                too_big_next = mul_p > boc_pkg::FULL_W'(MAX_BRICKS);
                count_next   = (mul_p > boc_pkg::FULL_W'(MAX_BRICKS)) ? '0 : CNT_W'(mul_p);
                state_next   = boc_pkg::ST_IDLE;
            end
            boc_pkg::ST_DIV_X:
            begin
                if (div_last)
                begin
                    // x = i mod gx; then (i / gx) splits into y and z by gy
                    cx_next      = CW'(div_rem_step);
                    div_rem_next = '0;
                    div_quo_next = div_quo_step;
                    div_den_next = gy_reg;
                    div_cnt_next = '0;
                    state_next   = boc_pkg::ST_DIV_Y;
                end
            end
            boc_pkg::ST_DIV_Y:
            begin
                if (div_last)
                begin
                    cy_next = CW'(div_rem_step);
                    cz_next = CW'(div_quo_step);
                    if (32'(idx_reg) >= 32'(count_reg))
                    begin
                        status_next = boc_pkg::STATUS_RANGE;
                        state_next  = boc_pkg::ST_DONE;
                    end
                    else
                    begin
                        status_next = boc_pkg::STATUS_OK;
                        state_next  = boc_pkg::ST_MEM_RD;
                    end
                end
            end
            boc_pkg::ST_MEM_RD:
            begin
                state_next = boc_pkg::ST_MEM_UPD;
            end
            boc_pkg::ST_MEM_UPD:
            begin
                occ_next   = |(new_byte & bit_mask);
                state_next = boc_pkg::ST_DONE;
            end
            boc_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, cz_reg, cy_reg, cx_reg, occ_reg};
                    m_tuser_next  = status_reg;
                    state_next    = boc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = boc_pkg::ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            dirty_next = 1'b1;
        end
    end

    // checks
    `BOC_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, s_tvalid && s_tready,
        state_reg != boc_pkg::ST_IDLE)
    `BOC_ASSERT_IMP(a_store_write_source, clk, rst_n, ram_wr_en,
        (state_reg == boc_pkg::ST_CLEAR) || ((state_reg == boc_pkg::ST_MEM_UPD) && req_reg))
    `BOC_ASSERT_IMP(a_oversize_no_count, clk, rst_n, too_big_reg, count_reg == '0)
    `BOC_ASSERT_IMP(a_capacity_zero_data, clk, rst_n,
        m_tvalid && (m_tuser == boc_pkg::STATUS_CAPACITY), m_tdata == '0)

endmodule

[src/boc_ram.sv]
// ---------------------------------------------------------------------------
// boc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module boc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
